// File: sv/frm_pkg.sv
// ----------------------------------------------------------------------------
// frm_pkg
// Shared constants and control types for the frame rate meter.
// ----------------------------------------------------------------------------
package frm_pkg;

    localparam int HISTORY_DEPTH = 64;

    localparam int STAMP_W  = 48;
    localparam int IVAL_W   = 32;
    localparam int RATE_W   = 30;
    localparam int QUO_W    = 24;
    localparam int FRAC_W   = 8;
    localparam int PTR_W    = $clog2(HISTORY_DEPTH);
    localparam int CNT_W    = $clog2(HISTORY_DEPTH + 1);
    localparam int SUM_W    = IVAL_W + PTR_W;
    localparam int NUM_W    = RATE_W + CNT_W + FRAC_W;
    localparam int NUMHI_W  = NUM_W - QUO_W;
    localparam int STEP_W   = $clog2(QUO_W);
    localparam int OUT_W    = IVAL_W + STAMP_W + QUO_W;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_INTERVAL = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_RATE    = CFG_IDX_W'(1);

    localparam logic [IVAL_W-1:0] MAX_INTERVAL_RST = IVAL_W'(100000);
    localparam logic [RATE_W-1:0] TICK_RATE_RST    = RATE_W'(1000000);
    localparam logic [QUO_W-1:0]  RATE_SAT         = {QUO_W{1'b1}};

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture input stamp
        logic diff;      // stamp - previous
        logic clamp;     // clamp interval, read oldest ring entry
        logic sub;       // drop oldest entry from window sum
        logic add;       // add interval, write ring
        logic mul;       // numerator = rate * count * 256
        logic check;     // saturation test, divider setup
        logic div_step;  // one quotient bit
        logic emit;      // load output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic out_free;
    } t_status;

endpackage

// File: sv/frm_ctrl.sv
// ----------------------------------------------------------------------------
// frm_ctrl
// Sequencer for one frame stamp: difference, clamp, window update, numerator,
// saturation check, bit-serial divide, result hand-off.
// ----------------------------------------------------------------------------
module frm_ctrl
    import frm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_status i_status,
    output logic    o_in_ready,
    output t_cmd    o_cmd
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_DIFF  = 9'b000000010,
        S_CLAMP = 9'b000000100,
        S_SUB   = 9'b000001000,
        S_ADD   = 9'b000010000,
        S_MUL   = 9'b000100000,
        S_CHECK = 9'b001000000,
        S_DIV   = 9'b010000000,
        S_DONE  = 9'b100000000
    } t_state;

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;

    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DIFF;
                end
            end
            S_DIFF: begin
                o_cmd.diff = 1'b1;
                n_state    = S_CLAMP;
            end
            S_CLAMP: begin
                o_cmd.clamp = 1'b1;
                n_state     = S_SUB;
            end
            S_SUB: begin
                o_cmd.sub = 1'b1;
                n_state   = S_ADD;
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                n_state   = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_CHECK;
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                n_step      = '0;
                n_state     = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_step         = r_step + STEP_W'(1);
                if (r_step == STEP_W'(QUO_W - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

endmodule

// File: sv/frm_dpath.sv
// ----------------------------------------------------------------------------
// frm_dpath
// Registers, interval ring, window sum, multiplier, restoring divider and
// output register of the frame rate meter.
// ----------------------------------------------------------------------------
module frm_dpath
    import frm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    input  logic [STAMP_W-1:0]    i_stamp,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [OUT_W-1:0]      o_out_data
);

    logic [IVAL_W-1:0]  r_max_ival;
    logic [RATE_W-1:0]  r_tick_rate;

    logic [STAMP_W-1:0] r_stamp;
    logic [STAMP_W-1:0] r_prev;
    logic [STAMP_W-1:0] r_diff;
    logic [IVAL_W-1:0]  r_ival;
    logic [STAMP_W-1:0] r_total;
    logic [PTR_W-1:0]   r_wptr;
    logic [CNT_W-1:0]   r_cnt;
    logic [SUM_W-1:0]   r_sum;
    logic [IVAL_W-1:0]  r_old;
    logic [NUM_W-1:0]   r_num;
    logic [QUO_W-1:0]   r_lo;
    logic [SUM_W-1:0]   r_rem;
    logic [QUO_W-1:0]   r_quo;
    logic               r_sat;

    logic               r_out_valid;
    logic [OUT_W-1:0]   r_out_data;

    logic [IVAL_W-1:0]  ring [HISTORY_DEPTH];

    logic [RATE_W+CNT_W-1:0] prod;
    logic [SUM_W-1:0]        num_hi;
    logic [SUM_W:0]          trial;
    logic                    ring_full;

    assign ring_full = (r_cnt == CNT_W'(HISTORY_DEPTH));
    assign prod      = (RATE_W+CNT_W)'(r_tick_rate) * (RATE_W+CNT_W)'(r_cnt);
    assign num_hi    = SUM_W'(r_num[NUM_W-1:QUO_W]);
    assign trial     = {r_rem, r_lo[QUO_W-1]};

    // ring storage, registered read of the oldest entry
    always_ff @(posedge i_clk) begin
        if (i_cmd.clamp) begin
            r_old <= ring[r_wptr];
        end
        if (i_cmd.add) begin
            ring[r_wptr] <= r_ival;
        end
    end

    // control-side state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_ival  <= MAX_INTERVAL_RST;
            r_tick_rate <= TICK_RATE_RST;
            r_prev      <= '0;
            r_total     <= '0;
            r_wptr      <= '0;
            r_cnt       <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_MAX_INTERVAL) begin
                    r_max_ival <= i_cfg_data[IVAL_W-1:0];
                end else if (i_cfg_index == CFG_TICK_RATE) begin
                    r_tick_rate <= i_cfg_data[RATE_W-1:0];
                end
            end
            if (i_cmd.diff) begin
                r_prev <= r_stamp;
            end
            if (i_cmd.sub && ring_full) begin
                r_sum <= r_sum - SUM_W'(r_old);
            end
            if (i_cmd.add) begin
                r_sum   <= r_sum + SUM_W'(r_ival);
                r_total <= r_total + STAMP_W'(r_ival);
                r_wptr  <= (r_wptr == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : r_wptr + PTR_W'(1);
                if (!ring_full) begin
                    r_cnt <= r_cnt + CNT_W'(1);
                end
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_stamp <= i_stamp;
        end
        if (i_cmd.diff) begin
            r_diff <= r_stamp - r_prev;
        end
        if (i_cmd.clamp) begin
            r_ival <= (r_diff > STAMP_W'(r_max_ival)) ? r_max_ival : r_diff[IVAL_W-1:0];
        end
        if (i_cmd.mul) begin
            r_num <= {prod, {FRAC_W{1'b0}}};
        end
        if (i_cmd.check) begin
            // quotient needs more than QUO_W bits (or sum is zero)
            r_sat <= (num_hi >= r_sum);
            r_rem <= num_hi;
            r_lo  <= r_num[QUO_W-1:0];
            r_quo <= '0;
        end
        if (i_cmd.div_step) begin
            r_lo <= {r_lo[QUO_W-2:0], 1'b0};
            if (trial >= {1'b0, r_sum}) begin
                r_rem <= SUM_W'(trial - {1'b0, r_sum});
                r_quo <= {r_quo[QUO_W-2:0], 1'b1};
            end else begin
                r_rem <= trial[SUM_W-1:0];
                r_quo <= {r_quo[QUO_W-2:0], 1'b0};
            end
        end
        if (i_cmd.emit) begin
            r_out_data <= {(r_sat ? RATE_SAT : r_quo), r_total, r_ival};
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out_data;

endmodule

// File: sv/frame_rate_meter.sv
// ----------------------------------------------------------------------------
// frame_rate_meter
// Frame interval, running tick total and windowed mean frame rate (Q8).
// ----------------------------------------------------------------------------
//  channel   direction  handshake                    payload
//  s_axis    in         s_axis_tvalid/s_axis_tready  frame_stamp
//  m_axis    out        m_axis_tvalid/m_axis_tready  interval, total, rate_q8
//  cfg       in         i_cfg_valid/o_cfg_ready      register index, data
//
//  One request passes through the accept state, the difference, clamp,
//  window update, numerator and saturation check states, the bit-serial
//  restoring divider (one quotient bit per step, 24-bit quotient) and a
//  hand-off state, in which the output register is loaded.
//  The input is taken only between requests; a result waiting in the output
//  register stalls only the hand-off of the request behind it.
//  Synchronous active-low reset; the ring needs no clearing pass.
//  Config writes are always accepted.
// ----------------------------------------------------------------------------
module frame_rate_meter
    import frm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [STAMP_W-1:0]    s_axis_tdata,   // [47:0] frame_stamp
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_W-1:0]      m_axis_tdata,   // [31:0] frame_interval,
                                                  // [79:32] elapsed_total,
                                                  // [103:80] rate_q8
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    frm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_status   (status),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd)
    );

    frm_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_stamp     (s_axis_tdata),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata)
    );

endmodule

// File: verif/frame_rate_meter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_rate_meter_tb
// Self-checking bench: frame stamps in, interval/total/rate results checked
// against a cycle-free predictor of the meter, under random stalls on both
// streams and several clamp and tick-rate settings.
// ----------------------------------------------------------------------------
module frame_rate_meter_tb;
    import frm_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 9;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int REPORT_MAX    = 10;

    // no register behind this index, writes must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = CFG_IDX_W'(2);

    typedef enum logic {REQ_FRAME, REQ_WRITE} t_req_kind;

    typedef struct packed {
        t_req_kind              kind;
        logic [STAMP_W-1:0]     stamp;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_DATA_W-1:0]  data;
        logic [7:0]             send_pct;
        logic [7:0]             recv_pct;
    } t_stim_req;

    typedef struct packed {
        logic [IVAL_W-1:0]  interval;
        logic [STAMP_W-1:0] total;
        logic [QUO_W-1:0]   rate;
    } t_frame_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [STAMP_W-1:0]    s_axis_tdata = '0;   // [47:0] frame_stamp
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_W-1:0]      m_axis_tdata;        // [31:0] frame_interval,
                                                // [79:32] elapsed_total,
                                                // [103:80] rate_q8
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    frame_rate_meter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // meter predictor state
    // ------------------------------------------------------------------
    logic [IVAL_W-1:0]  clamp_ticks = MAX_INTERVAL_RST;
    logic [RATE_W-1:0]  tick_hz     = TICK_RATE_RST;
    logic [STAMP_W-1:0] last_stamp  = '0;
    logic [STAMP_W-1:0] run_total   = '0;
    logic [IVAL_W-1:0]  ring [HISTORY_DEPTH];
    int                 ring_ptr    = 0;
    int                 ring_fill   = 0;
    logic [SUM_W-1:0]   win_sum     = '0;

    t_frame_result pending_results[$];
    t_stim_req     stim_queue[$];
    int            mismatches = 0;
    int            cycle_count = 0;

    function automatic t_frame_result measure_frame(logic [STAMP_W-1:0] stamp);
        logic [STAMP_W-1:0] delta;
        logic [IVAL_W-1:0]  ival;
        logic [63:0]        numer;
        logic [63:0]        quot;
        t_frame_result      res;
        delta = stamp - last_stamp;
        ival = (delta > STAMP_W'(clamp_ticks)) ? clamp_ticks : delta[IVAL_W-1:0];
        run_total = run_total + STAMP_W'(ival);
        // full window: oldest slot leaves the sum before it is overwritten
        if (ring_fill == HISTORY_DEPTH)
            win_sum = win_sum - SUM_W'(ring[ring_ptr]);
        else
            ring_fill = ring_fill + 1;
        ring[ring_ptr] = ival;
        win_sum = win_sum + SUM_W'(ival);
        ring_ptr = (ring_ptr == HISTORY_DEPTH - 1) ? 0 : ring_ptr + 1;
        if (win_sum == '0) begin
            res.rate = RATE_SAT;
        end else begin
            numer = 64'(tick_hz) * 64'(ring_fill) * 64'd256;
            quot = numer / 64'(win_sum);
            res.rate = (quot > 64'(RATE_SAT)) ? RATE_SAT : quot[QUO_W-1:0];
        end
        last_stamp = stamp;
        res.interval = ival;
        res.total = run_total;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // stimulus building
    // ------------------------------------------------------------------
    logic [STAMP_W-1:0] gen_stamp = '0;
    logic [IVAL_W-1:0]  gen_clamp = MAX_INTERVAL_RST;
    logic [7:0]         cur_send_pct = 8'd30;
    logic [7:0]         cur_recv_pct = 8'd30;

    task automatic add_frame(input logic [STAMP_W-1:0] stamp);
        t_stim_req r;
        r = '0;
        r.kind = REQ_FRAME;
        r.stamp = stamp;
        r.send_pct = cur_send_pct;
        r.recv_pct = cur_recv_pct;
        stim_queue.insert(stim_queue.size(), r);
        gen_stamp = stamp;
    endtask

    task automatic add_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        t_stim_req r;
        r = '0;
        r.kind = REQ_WRITE;
        r.idx = idx;
        r.data = data;
        stim_queue.insert(stim_queue.size(), r);
        if (idx == CFG_MAX_INTERVAL)
            gen_clamp = data[IVAL_W-1:0];
    endtask

    // mostly steady frame streams, with jitter around the clamp, stalls,
    // backward jumps and raw random stamps mixed in
    task automatic add_random_frames(input int count);
        logic [63:0] span;
        logic [63:0] raw;
        int          pick;
        for (int n = 0; n < count; n++) begin
            span = 64'(gen_clamp) + 64'(gen_clamp) / 4 + 64'd2;
            raw = {$urandom, $urandom};
            pick = $urandom_range(0, 99);
            if (pick < 65)
                add_frame(gen_stamp + STAMP_W'(raw % span));
            else if (pick < 73)
                add_frame(gen_stamp + STAMP_W'($urandom_range(0, 3)));
            else if (pick < 80)
                add_frame(gen_stamp + STAMP_W'(gen_clamp) + STAMP_W'($urandom_range(0, 2))
                          - STAMP_W'(1));
            else if (pick < 88)
                add_frame(gen_stamp - STAMP_W'(1 + $urandom_range(0, 1000000)));
            else
                add_frame(raw[STAMP_W-1:0]);
        end
    endtask

    function automatic logic [CFG_DATA_W-1:0] random_clamp();
        unique case ($urandom_range(0, 3))
            0: return $urandom_range(1, 5000);
            1: return $urandom_range(100000, 2000000);
            2: return $urandom;
            default: return $urandom_range(1, 64);
        endcase
    endfunction

    function automatic logic [7:0] random_pct();
        unique case ($urandom_range(0, 2))
            0: return 8'd0;
            1: return 8'd20;
            default: return 8'd45;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // driver: stamp stream and register writes
    // ------------------------------------------------------------------
    int        gap_left = 0;
    int        quiet = 0;
    logic      busy;
    logic      next_valid;
    logic      next_cfg_valid;
    t_stim_req head;
    logic [7:0] m_recv_pct = 8'd0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            busy = (s_axis_tvalid && !s_axis_tready) || (i_cfg_valid && !o_cfg_ready);
            next_valid = busy ? s_axis_tvalid : 1'b0;
            next_cfg_valid = busy ? i_cfg_valid : 1'b0;
            if (pending_results.size() == 0 && !s_axis_tvalid)
                quiet = quiet + 1;
            else
                quiet = 0;
            if (!busy) begin
                if (gap_left != 0) begin
                    gap_left = gap_left - 1;
                end else if (stim_queue.size() != 0) begin
                    head = stim_queue[0];
                    if (head.kind == REQ_FRAME) begin
                        void'(stim_queue.pop_front());
                        next_valid = 1'b1;
                        s_axis_tdata <= head.stamp;
                        m_recv_pct <= head.recv_pct;
                        if ($urandom_range(0, 99) < int'(head.send_pct))
                            gap_left = $urandom_range(1, 19);
                    end else if (quiet >= SETTLE_CYCLES) begin
                        // register writes only once the meter has drained
                        void'(stim_queue.pop_front());
                        next_cfg_valid = 1'b1;
                        i_cfg_index <= head.idx;
                        i_cfg_data <= head.data;
                    end
                end
            end
            s_axis_tvalid <= next_valid;
            i_cfg_valid <= next_cfg_valid;
        end
    end

    // ------------------------------------------------------------------
    // monitor: predicts on accepted requests, checks accepted results
    // ------------------------------------------------------------------
    int                 stall_left = 0;
    t_frame_result      want;
    logic [IVAL_W-1:0]  got_interval;
    logic [STAMP_W-1:0] got_total;
    logic [QUO_W-1:0]   got_rate;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got_interval = m_axis_tdata[IVAL_W-1:0];
                got_total = m_axis_tdata[IVAL_W +: STAMP_W];
                got_rate = m_axis_tdata[IVAL_W + STAMP_W +: QUO_W];
                if (pending_results.size() == 0) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= REPORT_MAX)
                        $display("unexpected result: interval %h total %h rate %h",
                                 got_interval, got_total, got_rate);
                end else begin
                    want = pending_results.pop_front();
                    if (got_interval !== want.interval || got_total !== want.total
                        || got_rate !== want.rate) begin
                        mismatches = mismatches + 1;
                        if (mismatches <= REPORT_MAX)
                            $display("mismatch (exp/act): interval %h/%h total %h/%h rate %h/%h",
                                     want.interval, got_interval, want.total, got_total,
                                     want.rate, got_rate);
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_MAX_INTERVAL: clamp_ticks = i_cfg_data[IVAL_W-1:0];
                    CFG_TICK_RATE:    tick_hz = i_cfg_data[RATE_W-1:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                pending_results.insert(pending_results.size(), measure_frame(s_axis_tdata));
            if (stall_left != 0) begin
                stall_left = stall_left - 1;
                m_axis_tready <= 1'b0;
            end else if ($urandom_range(0, 399) < int'(m_recv_pct)) begin
                stall_left = $urandom_range(1, 19) - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin
        // directed: first frame from zero, zero sum, tiny sum, clamp,
        // backward stamp, wrap at the top of the counter
        add_frame(48'd0);
        add_frame(48'd0);
        add_frame(48'd1);
        add_frame(48'd40001);
        add_frame(48'd56668);
        add_frame(48'd1000000);
        add_frame(48'd500);
        add_frame({STAMP_W{1'b1}});
        add_frame(48'd0);
        add_frame(48'h0000_0001_0000);
        // zero clamp forces every interval to zero
        add_write(CFG_MAX_INTERVAL, 32'd0);
        add_frame(48'h0000_0002_0000);
        add_frame(48'h8000_0000_0000);
        add_frame(48'h7FFF_FFFF_FFFF);
        // widest clamp, zero tick rate
        add_write(CFG_MAX_INTERVAL, 32'hFFFF_FFFF);
        add_write(CFG_TICK_RATE, 32'd0);
        add_frame(gen_stamp + 48'h0000_FFFF_FFFF);
        add_frame(gen_stamp + 48'h0001_0000_0005);
        add_frame(gen_stamp + 48'd7);
        // over-wide tick rate is truncated, stray index is dropped
        add_write(CFG_TICK_RATE, 32'hFFFF_FFFF);
        add_write(CFG_NO_REG, 32'd0);
        add_write(8'hFF, 32'h1234_5678);
        add_frame(gen_stamp + 48'd3);
        add_frame(gen_stamp + 48'd1000);
        add_frame(gen_stamp + 48'h0000_8000_0000);
        add_write(CFG_MAX_INTERVAL, 32'd1);
        add_write(CFG_TICK_RATE, 32'd1);
        add_frame(gen_stamp + 48'd5);
        add_frame(gen_stamp);
        add_frame(gen_stamp + 48'd1);

        // random phases over several settings
        add_write(CFG_MAX_INTERVAL, 32'(MAX_INTERVAL_RST));
        add_write(CFG_TICK_RATE, 32'(TICK_RATE_RST));
        add_random_frames(300);
        cur_send_pct = 8'd0;
        cur_recv_pct = 8'd0;
        add_write(CFG_MAX_INTERVAL, 32'hFFFF_FFFF);
        add_write(CFG_TICK_RATE, 32'd1000000000);
        add_random_frames(250);
        // clamp of zero long enough to empty the window sum
        cur_send_pct = 8'd50;
        cur_recv_pct = 8'd10;
        add_write(CFG_MAX_INTERVAL, 32'd0);
        add_random_frames(90);
        cur_send_pct = 8'd10;
        cur_recv_pct = 8'd50;
        add_write(CFG_MAX_INTERVAL, 32'd1);
        add_write(CFG_TICK_RATE, 32'd1);
        add_random_frames(150);
        for (int p = 0; p < 5; p++) begin
            cur_send_pct = random_pct();
            cur_recv_pct = random_pct();
            add_write(CFG_MAX_INTERVAL, random_clamp());
            if ($urandom_range(0, 3) == 0)
                add_write(CFG_TICK_RATE, $urandom);
            else
                add_write(CFG_TICK_RATE, $urandom_range(1, 1000000000));
            add_write(CFG_IDX_W'($urandom_range(2, 255)), $urandom);
            add_random_frames(150);
        end
        // closing stretch without idling
        cur_send_pct = 8'd0;
        cur_recv_pct = 8'd0;
        add_write(CFG_MAX_INTERVAL, 32'(MAX_INTERVAL_RST));
        add_write(CFG_TICK_RATE, 32'(TICK_RATE_RST));
        add_random_frames(100);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (stim_queue.size() != 0 || s_axis_tvalid || i_cfg_valid
               || pending_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && pending_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: filelist.f
sv/frm_pkg.sv
sv/frm_ctrl.sv
sv/frm_dpath.sv
sv/frame_rate_meter.sv
verif/frame_rate_meter_tb.sv
